/* rtl/core/gtl_pkg.sv */
package gtl_pkg;

	// node and field widths
	localparam int MAX_NODES = 16;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int MASK_W    = MAX_NODES;
	localparam int NCNT_W    = 5;
	localparam int COEF_W    = 8;
	// a*lo + b*hi stays below 2 * 255 * 16
	localparam int SUM_W     = 13;
	localparam int SQ_W      = 2 * SUM_W;
	localparam int WGT_W     = 27;
	localparam int TOTAL_W   = 31;
	localparam int OUT_W     = 30;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	// what an edge evaluation is for
	typedef enum logic [1:0] {
		EV_SEED  = 2'd0,
		EV_TAIL  = 2'd1,
		EV_HEAD  = 2'd2,
		EV_CLOSE = 2'd3
	} eval_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_SEED_DRAIN,
		ST_SEED_COMMIT,
		ST_CHECK,
		ST_GROW,
		ST_GROW_DRAIN,
		ST_GROW_COMMIT,
		ST_CLOSE,
		ST_CLOSE_DRAIN,
		ST_FINISH
	} gtl_state_t;

	typedef struct packed {
		logic              start;
		logic [MASK_W-1:0] node_mask;
		logic              issue;
		eval_kind_t        kind;
		logic [IDX_W-1:0]  node_i;
		logic [IDX_W-1:0]  node_j;
		logic              seed_commit;
		logic              grow_commit;
		logic              finish;
	} gtl_cmd_t;

	typedef struct packed {
		logic [MASK_W-1:0] unvisited;
		logic              busy;
		logic              out_full;
	} gtl_stat_t;

	// one bit per node below n
	function automatic logic [MASK_W-1:0] nodes_below(input logic [NCNT_W-1:0] n);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int k = 0; k < MASK_W; k++) begin
			m[k] = (NCNT_W'(k) < n);
		end
		return m;
	endfunction

	function automatic logic [MASK_W-1:0] node_bit(input logic [IDX_W-1:0] idx);
		logic [MASK_W-1:0] m;
		m = '0;
		m[idx] = 1'b1;
		return m;
	endfunction

endpackage

/* rtl/core/gtl_ctrl.sv */
module gtl_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [gtl_pkg::NCNT_W-1:0] in_node_count,
	output logic                       ready,
	input  gtl_pkg::gtl_stat_t         stat,
	output gtl_pkg::gtl_cmd_t          cmd
);

	gtl_pkg::gtl_state_t state_q, state_d;
	logic [gtl_pkg::IDX_W-1:0] i_q, i_d;
	logic [gtl_pkg::IDX_W-1:0] j_q, j_d;
	logic [gtl_pkg::IDX_W-1:0] v_q, v_d;
	logic [gtl_pkg::IDX_W-1:0] last_q, last_d;
	logic side_q, side_d;
	logic [gtl_pkg::NCNT_W-1:0] n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gtl_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			v_q     <= '0;
			last_q  <= '0;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			v_q     <= v_d;
			last_q  <= last_d;
			side_q  <= side_d;
		end
	end

	always_comb begin
		if (in_node_count > gtl_pkg::NCNT_W'(gtl_pkg::MAX_NODES)) begin
			n_eff = gtl_pkg::NCNT_W'(gtl_pkg::MAX_NODES);
		end else begin
			n_eff = in_node_count;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		v_d     = v_q;
		last_d  = last_q;
		side_d  = side_q;
		cmd     = '0;
		ready   = 1'b0;
		case (state_q)
			gtl_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (in_valid) begin
					cmd.start     = 1'b1;
					cmd.node_mask = gtl_pkg::nodes_below(n_eff);
					i_d    = '0;
					j_d    = '0;
					last_d = gtl_pkg::IDX_W'(n_eff - gtl_pkg::NCNT_W'(1));
					if (in_node_count < gtl_pkg::NCNT_W'(2)) begin
						state_d = gtl_pkg::ST_FINISH;
					end else begin
						state_d = gtl_pkg::ST_SEED;
					end
				end
			end
			gtl_pkg::ST_SEED: begin
				cmd.issue  = (i_q != j_q);
				cmd.kind   = gtl_pkg::EV_SEED;
				cmd.node_i = i_q;
				cmd.node_j = j_q;
				if (j_q == last_q) begin
					j_d = '0;
					if (i_q == last_q) begin
						state_d = gtl_pkg::ST_SEED_DRAIN;
					end else begin
						i_d = i_q + gtl_pkg::IDX_W'(1);
					end
				end else begin
					j_d = j_q + gtl_pkg::IDX_W'(1);
				end
			end
			gtl_pkg::ST_SEED_DRAIN: begin
				if (!stat.busy) begin
					state_d = gtl_pkg::ST_SEED_COMMIT;
				end
			end
			gtl_pkg::ST_SEED_COMMIT: begin
				cmd.seed_commit = 1'b1;
				state_d = gtl_pkg::ST_CHECK;
			end
			gtl_pkg::ST_CHECK: begin
				v_d    = '0;
				side_d = 1'b0;
				if (stat.unvisited == '0) begin
					state_d = gtl_pkg::ST_CLOSE;
				end else begin
					state_d = gtl_pkg::ST_GROW;
				end
			end
			gtl_pkg::ST_GROW: begin
				// tail edge first, then head edge, for every unvisited node
				cmd.issue  = stat.unvisited[v_q];
				cmd.kind   = side_q ? gtl_pkg::EV_HEAD : gtl_pkg::EV_TAIL;
				cmd.node_j = v_q;
				if (stat.unvisited[v_q] && !side_q) begin
					side_d = 1'b1;
				end else begin
					side_d = 1'b0;
					if (v_q == last_q) begin
						state_d = gtl_pkg::ST_GROW_DRAIN;
					end else begin
						v_d = v_q + gtl_pkg::IDX_W'(1);
					end
				end
			end
			gtl_pkg::ST_GROW_DRAIN: begin
				if (!stat.busy) begin
					state_d = gtl_pkg::ST_GROW_COMMIT;
				end
			end
			gtl_pkg::ST_GROW_COMMIT: begin
				cmd.grow_commit = 1'b1;
				state_d = gtl_pkg::ST_CHECK;
			end
			gtl_pkg::ST_CLOSE: begin
				cmd.issue = 1'b1;
				cmd.kind  = gtl_pkg::EV_CLOSE;
				state_d   = gtl_pkg::ST_CLOSE_DRAIN;
			end
			gtl_pkg::ST_CLOSE_DRAIN: begin
				if (!stat.busy) begin
					state_d = gtl_pkg::ST_FINISH;
				end
			end
			gtl_pkg::ST_FINISH: begin
				if (!stat.out_full) begin
					cmd.finish = 1'b1;
					state_d = gtl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gtl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/gtl_dpath.sv */
module gtl_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gtl_pkg::gtl_cmd_t          cmd,
	input  logic [gtl_pkg::COEF_W-1:0] coef_low,
	input  logic [gtl_pkg::COEF_W-1:0] coef_high,
	output gtl_pkg::gtl_stat_t         stat,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [gtl_pkg::OUT_W-1:0]  cycle_length
);

	logic [gtl_pkg::COEF_W-1:0]  coef_a_q, coef_b_q;
	logic [gtl_pkg::IDX_W-1:0]   head_q, tail_q;
	logic [gtl_pkg::MASK_W-1:0]  mask_q;
	logic [gtl_pkg::TOTAL_W-1:0] total_q;
	logic [gtl_pkg::WGT_W-1:0]   best_w_q;
	logic [gtl_pkg::IDX_W-1:0]   best_x_q, best_y_q;
	gtl_pkg::eval_kind_t         best_kind_q;
	logic                        found_q;
	logic                        out_valid_q;
	logic [gtl_pkg::OUT_W-1:0]   result_q;

	// evaluation pipeline
	logic                        valid_s1, valid_s2;
	gtl_pkg::eval_kind_t         kind_s1, kind_s2;
	logic [gtl_pkg::IDX_W-1:0]   x_s1, y_s1, x_s2, y_s2;
	logic [gtl_pkg::SUM_W-1:0]   sum_s1;
	logic [gtl_pkg::WGT_W-1:0]   w_s2;

	logic [gtl_pkg::IDX_W-1:0]        ev_x, ev_y;
	logic [gtl_pkg::IDX_W:0]          ev_lo, ev_hi;
	logic [gtl_pkg::COEF_W+gtl_pkg::IDX_W:0] prod_lo, prod_hi;
	logic [gtl_pkg::SQ_W-1:0]         sq;
	logic                             better;

	always_comb begin
		case (cmd.kind)
			gtl_pkg::EV_SEED:  ev_x = cmd.node_i;
			gtl_pkg::EV_TAIL:  ev_x = tail_q;
			gtl_pkg::EV_HEAD:  ev_x = head_q;
			gtl_pkg::EV_CLOSE: ev_x = head_q;
			default:           ev_x = head_q;
		endcase
		ev_y = (cmd.kind == gtl_pkg::EV_CLOSE) ? tail_q : cmd.node_j;
		if (ev_x < ev_y) begin
			ev_lo = {1'b0, ev_x} + (gtl_pkg::IDX_W+1)'(1);
			ev_hi = {1'b0, ev_y} + (gtl_pkg::IDX_W+1)'(1);
		end else begin
			ev_lo = {1'b0, ev_y} + (gtl_pkg::IDX_W+1)'(1);
			ev_hi = {1'b0, ev_x} + (gtl_pkg::IDX_W+1)'(1);
		end
		prod_lo = (gtl_pkg::COEF_W+gtl_pkg::IDX_W+1)'(coef_a_q)
			* (gtl_pkg::COEF_W+gtl_pkg::IDX_W+1)'(ev_lo);
		prod_hi = (gtl_pkg::COEF_W+gtl_pkg::IDX_W+1)'(coef_b_q)
			* (gtl_pkg::COEF_W+gtl_pkg::IDX_W+1)'(ev_hi);
	end

	assign sq     = gtl_pkg::SQ_W'(sum_s1) * gtl_pkg::SQ_W'(sum_s1);
	assign better = !found_q || (w_s2 < best_w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= cmd.kind;
		x_s1    <= ev_x;
		y_s1    <= ev_y;
		sum_s1  <= gtl_pkg::SUM_W'(prod_lo) + gtl_pkg::SUM_W'(prod_hi);
		kind_s2 <= kind_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		w_s2    <= gtl_pkg::WGT_W'(sq) + gtl_pkg::WGT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q    <= '0;
			coef_b_q    <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			mask_q      <= '0;
			total_q     <= '0;
			best_w_q    <= '0;
			best_x_q    <= '0;
			best_y_q    <= '0;
			best_kind_q <= gtl_pkg::EV_SEED;
			found_q     <= 1'b0;
		end else begin
			if (cmd.start) begin
				coef_a_q <= coef_low;
				coef_b_q <= coef_high;
				head_q   <= '0;
				tail_q   <= '0;
				mask_q   <= cmd.node_mask;
				total_q  <= '0;
				found_q  <= 1'b0;
			end else if (cmd.seed_commit) begin
				head_q  <= best_x_q;
				tail_q  <= best_y_q;
				total_q <= gtl_pkg::TOTAL_W'(best_w_q);
				mask_q  <= mask_q & ~gtl_pkg::node_bit(best_x_q) & ~gtl_pkg::node_bit(best_y_q);
				found_q <= 1'b0;
			end else if (cmd.grow_commit) begin
				if (best_kind_q == gtl_pkg::EV_TAIL) begin
					tail_q <= best_y_q;
				end else begin
					head_q <= best_y_q;
				end
				total_q <= total_q + gtl_pkg::TOTAL_W'(best_w_q);
				mask_q  <= mask_q & ~gtl_pkg::node_bit(best_y_q);
				found_q <= 1'b0;
			end else if (valid_s2) begin
				if (kind_s2 == gtl_pkg::EV_CLOSE) begin
					total_q <= total_q + gtl_pkg::TOTAL_W'(w_s2);
				end else if (better) begin
					// strict improvement only, so the first minimum stays
					best_w_q    <= w_s2;
					best_x_q    <= x_s2;
					best_y_q    <= y_s2;
					best_kind_q <= kind_s2;
					found_q     <= 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q <= total_q[gtl_pkg::OUT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign cycle_length   = result_q;
	assign stat.unvisited = mask_q;
	assign stat.busy      = valid_s1 || valid_s2;
	assign stat.out_full  = out_valid_q;

`ifndef SYNTH
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seed_commit || cmd.grow_commit) |-> !(valid_s1 || valid_s2))
		else $error("commit while evaluations in flight");

	a_grow_one_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grow_commit |=> ($countones(mask_q) == $countones($past(mask_q)) - 1))
		else $error("grow step did not visit exactly one node");

	a_seed_ends_differ: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seed_commit |=> (head_q != tail_q))
		else $error("seed edge has equal ends");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !out_valid_q)
		else $error("result written over a pending one");
`endif

endmodule

/* rtl/core/greedy_tour_length.sv */
// greedy_tour_length: greedy double-ended nearest-neighbor tour length
//
// input channel (s_axis): one transaction per problem, carrying n, the
// number of nodes, and the coefficients coef_low and coef_high; the edge
// weight between nodes is rebuilt on the fly, nothing is stored per edge
// output channel (m_axis): one transaction per problem with the cycle length
//
// the edges are evaluated by the single edge-weight pipeline (two stages,
// at most one evaluation issued per cycle, none while it drains), and that
// pipeline is drained before each commit.
// n below 2 gives 0 without a search; n above 16 works as 16
// one problem is processed at a time; tready is high only while idle
//
// the result sits in an output register, so a new problem is taken while the
// previous result still waits; if the receiver stalls, the next result is
// held back until the register frees up
// reset clears the controller, the pipeline valids and the output valid
module greedy_tour_length (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// node_count[4:0], coef_low[12:5], coef_high[20:13], zero pad
	input  logic [gtl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// cycle_length[29:0], zero pad
	output logic [gtl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	// input field unpacking
	logic [gtl_pkg::NCNT_W-1:0] node_count;
	logic [gtl_pkg::COEF_W-1:0] coef_low;
	logic [gtl_pkg::COEF_W-1:0] coef_high;
	logic [gtl_pkg::OUT_W-1:0]  cycle_length;

	// controller to datapath commands and status back
	gtl_pkg::gtl_cmd_t  cmd;
	gtl_pkg::gtl_stat_t stat;
	logic               ready;

	assign node_count = s_axis_tdata[gtl_pkg::NCNT_W-1:0];
	assign coef_low   = s_axis_tdata[gtl_pkg::NCNT_W +: gtl_pkg::COEF_W];
	assign coef_high  = s_axis_tdata[gtl_pkg::NCNT_W+gtl_pkg::COEF_W +: gtl_pkg::COEF_W];

	// sequencer: seed scan, grow rounds, closing edge
	gtl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_node_count (node_count),
		.ready         (ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	// weight pipeline, best-candidate tracking, path state and result register
	gtl_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.coef_low     (coef_low),
		.coef_high    (coef_high),
		.stat         (stat),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.cycle_length (cycle_length)
	);

	assign s_axis_tready = ready;
	assign m_axis_tdata  = {{(gtl_pkg::OUT_DATA_W-gtl_pkg::OUT_W){1'b0}}, cycle_length};

endmodule
